// ===== hw/rtl/iris_rubber_sheet_coordinate_map_assert.svh =====
// Assertion macros for the iris rubber-sheet coordinate map.
// Needs clk and arst_n in the scope of use; no other dependencies.
`ifndef IRIS_RUBBER_SHEET_COORDINATE_MAP_ASSERT_SVH
`define IRIS_RUBBER_SHEET_COORDINATE_MAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IRSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/irsm_pkg.sv =====
// Shared constants, register codes and a helper function of the rubber-sheet map.
// No dependencies.
package irsm_pkg;

	localparam int DEF_COORD_BITS       = 10;
	localparam int DEF_SINE_TABLE_DEPTH = 1024;
	localparam int DEF_TRIG_FRAC_BITS   = 15;

	localparam int COORD_FRAC = 8;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 10;
	localparam int CTR_W      = 10;
	localparam int RAD_W      = 9;
	localparam int IMG_W      = 11;
	localparam int OUT_W      = 12;
	localparam int GW_W       = 12;  // unwrapped width w
	localparam int GH_W       = 10;  // unwrapped height h
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int ITEM_W     = 2 * OUT_W + 2;

	localparam logic [33:0] PI_Q32 = 34'd13493037705;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PUPIL_X,
		REG_PUPIL_Y,
		REG_PUPIL_R,
		REG_LIMBUS_X,
		REG_LIMBUS_Y,
		REG_LIMBUS_R,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic [CTR_W-1:0] pupil_x;
		logic [CTR_W-1:0] pupil_y;
		logic [RAD_W-1:0] pupil_r;
		logic [CTR_W-1:0] limbus_x;
		logic [CTR_W-1:0] limbus_y;
		logic [RAD_W-1:0] limbus_r;
		logic [IMG_W-1:0] image_width;
		logic [IMG_W-1:0] image_height;
	} cfg_t;

	// w = round(2 * r * pi), pi in Q32
	function automatic logic [GW_W-1:0] grid_width(input logic [RAD_W-1:0] r);
		logic [43:0] prod;
		prod = 44'({r, 1'b0}) * 44'(PI_Q32) + (44'd1 << 31);
		return prod[43:32];
	endfunction

endpackage

// ===== hw/rtl/iris_rubber_sheet_coordinate_map.sv =====
// Path from push to the result ports: input queue, phase divider, table read,
// points, blend, coordinate dividers and the result queue. Throughput: one
// transaction per cycle; the whole pipeline advances while the two-entry result
// queue has room.
// Reset (arst_n low, asynchronous) empties both queues and the pipeline and loads
// the register reset values; the sine table is constant and needs no fill.
module iris_rubber_sheet_coordinate_map #(
	parameter int COORD_BITS       = irsm_pkg::DEF_COORD_BITS,
	parameter int SINE_TABLE_DEPTH = irsm_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int TRIG_FRAC_BITS   = irsm_pkg::DEF_TRIG_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [irsm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [irsm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic [irsm_pkg::COL_W-1:0]            angle_column,
	input  logic [irsm_pkg::ROW_W-1:0]            radial_row,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [irsm_pkg::OUT_W-1:0]     source_x,
	output logic signed [irsm_pkg::OUT_W-1:0]     source_y,
	output logic                                  in_image,
	output logic                                  in_grid
);

	`include "iris_rubber_sheet_coordinate_map_assert.svh"

	localparam int PN_W = irsm_pkg::COL_W + $clog2(SINE_TABLE_DEPTH) + 4;
	localparam int QW   = PN_W + irsm_pkg::GW_W + 1 + 1 + irsm_pkg::ROW_W + 1;

	// configuration registers
	irsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pupil_x: '0, pupil_y: '0, pupil_r: '0, limbus_x: '0,
				limbus_y: '0, limbus_r: irsm_pkg::RAD_W'(1),
				image_width: irsm_pkg::IMG_W'(1024), image_height: irsm_pkg::IMG_W'(1024)};
		end else if (cfg_we) begin
			unique case (irsm_pkg::cfg_reg_t'(cfg_index))
				irsm_pkg::REG_PUPIL_X:      cfg_q.pupil_x      <= cfg_wdata[irsm_pkg::CTR_W-1:0];
				irsm_pkg::REG_PUPIL_Y:      cfg_q.pupil_y      <= cfg_wdata[irsm_pkg::CTR_W-1:0];
				irsm_pkg::REG_PUPIL_R:      cfg_q.pupil_r      <= cfg_wdata[irsm_pkg::RAD_W-1:0];
				irsm_pkg::REG_LIMBUS_X:     cfg_q.limbus_x     <= cfg_wdata[irsm_pkg::CTR_W-1:0];
				irsm_pkg::REG_LIMBUS_Y:     cfg_q.limbus_y     <= cfg_wdata[irsm_pkg::CTR_W-1:0];
				irsm_pkg::REG_LIMBUS_R:     cfg_q.limbus_r     <= cfg_wdata[irsm_pkg::RAD_W-1:0];
				irsm_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata;
				irsm_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front end: classify and form the phase dividend
	logic [PN_W-1:0]           f_num;
	logic [irsm_pkg::GW_W:0]   f_den;
	logic                      f_wzero;
	logic                      f_grid;

	irsm_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PN_W(PN_W)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.limbus_r     (cfg_q.limbus_r),
		.angle_column (angle_column),
		.radial_row   (radial_row),
		.ph_num       (f_num),
		.ph_den       (f_den),
		.w_zero       (f_wzero),
		.in_grid      (f_grid)
	);

	// queue between front and back end
	logic                       adv;
	logic                       q_empty;
	logic [QW-1:0]              q_dout;
	logic [PN_W-1:0]            b_num;
	logic [irsm_pkg::GW_W:0]    b_den;
	logic                       b_wzero;
	logic [irsm_pkg::ROW_W-1:0] b_row;
	logic                       b_grid;

	irsm_fifo #(.W(QW)) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_num, f_den, f_wzero, radial_row, f_grid}),
		.full   (full),
		.pop    (adv),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {b_num, b_den, b_wzero, b_row, b_grid} = q_dout;

	// back end
	logic                              o_vld;
	logic signed [irsm_pkg::OUT_W-1:0] o_x;
	logic signed [irsm_pkg::OUT_W-1:0] o_y;
	logic                              o_img;
	logic                              o_grid;
	logic                              out_full;

	assign adv = !out_full;

	irsm_back #(
		.COORD_BITS       (COORD_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.TRIG_FRAC_BITS   (TRIG_FRAC_BITS),
		.PN_W             (PN_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.cfg       (cfg_q),
		.in_valid  (!q_empty),
		.ph_num    (b_num),
		.ph_den    (b_den),
		.w_zero    (b_wzero),
		.row       (b_row),
		.grid      (b_grid),
		.out_valid (o_vld),
		.source_x  (o_x),
		.source_y  (o_y),
		.in_image  (o_img),
		.in_grid   (o_grid)
	);

	// result queue
	logic [irsm_pkg::ITEM_W-1:0] r_dout;

	irsm_fifo #(.W(irsm_pkg::ITEM_W)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_vld && adv),
		.din    ({o_x, o_y, o_img, o_grid}),
		.full   (out_full),
		.pop    (pop),
		.dout   (r_dout),
		.empty  (empty)
	);

	assign {source_x, source_y, in_image, in_grid} = r_dout;

	// checks
	`IRSM_ASSERT_IMP(a_no_result_overflow, o_vld && adv, !out_full, "result queue overflow")
	`IRSM_ASSERT_NEXT(a_accept_queued, push && !full, !q_empty, "accepted transaction lost")
	`IRSM_ASSERT_IMP(a_in_image_nonneg, !empty && in_image, !source_x[irsm_pkg::OUT_W-1] && !source_y[irsm_pkg::OUT_W-1], "in-image point with negative coordinate")

endmodule

// ===== hw/rtl/irsm_fifo.sv =====
// Two-entry queue with registered occupancy, used on both sides of the back end.
// No dependencies.
module irsm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule

// ===== hw/rtl/irsm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// No dependencies.
module irsm_div #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	logic          vld_s [1:NW];
	logic [NW-1:0] nq_s  [1:NW];
	logic [DW-1:0] rem_s [1:NW];
	logic [DW-1:0] den_s [1:NW];
	logic [TW-1:0] tag_s [1:NW];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic          cur_vld;
		logic [NW-1:0] cur_nq;
		logic [DW-1:0] cur_rem;
		logic [DW-1:0] cur_den;
		logic [TW-1:0] cur_tag;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          qbit;

		if (g == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_nq  = num;
			assign cur_rem = '0;
			assign cur_den = den;
			assign cur_tag = tag;
		end else begin : g_next
			assign cur_vld = vld_s[g];
			assign cur_nq  = nq_s[g];
			assign cur_rem = rem_s[g];
			assign cur_den = den_s[g];
			assign cur_tag = tag_s[g];
		end

		// shift in one numerator bit, subtract when it fits
		assign trial = {cur_rem, cur_nq[NW-1]};
		assign diff  = trial - {1'b0, cur_den};
		assign qbit  = (trial >= {1'b0, cur_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= qbit ? diff[DW-1:0] : trial[DW-1:0];
				nq_s[g+1]  <= {cur_nq[NW-2:0], qbit};
				den_s[g+1] <= cur_den;
				tag_s[g+1] <= cur_tag;
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = nq_s[NW];
	assign out_tag   = tag_s[NW];

endmodule

// ===== hw/rtl/irsm_front.sv =====
// Front end: derives the grid width, flags grid membership, forms the phase dividend.
// Depends on irsm_pkg.
module irsm_front #(
	parameter int SINE_TABLE_DEPTH = irsm_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int PN_W = irsm_pkg::COL_W + $clog2(SINE_TABLE_DEPTH) + 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [irsm_pkg::RAD_W-1:0]   limbus_r,
	input  logic [irsm_pkg::COL_W-1:0]   angle_column,
	input  logic [irsm_pkg::ROW_W-1:0]   radial_row,
	output logic [PN_W-1:0]              ph_num,
	output logic [irsm_pkg::GW_W:0]      ph_den,
	output logic                         w_zero,
	output logic                         in_grid
);

	localparam int LOGD = $clog2(SINE_TABLE_DEPTH);

	logic [irsm_pkg::GW_W-1:0] w_q;
	logic [irsm_pkg::GH_W-1:0] h;

	// the grid width register follows the limbus radius in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= irsm_pkg::grid_width(irsm_pkg::RAD_W'(1));
		end else begin
			w_q <= irsm_pkg::grid_width(limbus_r);
		end
	end

	assign h = {limbus_r, 1'b0};

	// phase = round(4D * col / w): dividend 2*col*4D + w over 2w
	assign ph_num  = PN_W'({angle_column, {(LOGD + 3){1'b0}}}) + PN_W'(w_q);
	assign ph_den  = {w_q, 1'b0};
	assign w_zero  = (w_q == '0);
	assign in_grid = (angle_column < w_q) && (radial_row < h);

endmodule

// ===== hw/rtl/irsm_back.sv =====
// Back end: phase divide, quarter-wave lookup, circle points, interpolation, rounding.
// Depends on irsm_pkg and irsm_div.
module irsm_back #(
	parameter int COORD_BITS       = irsm_pkg::DEF_COORD_BITS,
	parameter int SINE_TABLE_DEPTH = irsm_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int TRIG_FRAC_BITS   = irsm_pkg::DEF_TRIG_FRAC_BITS,
	parameter int PN_W = irsm_pkg::COL_W + $clog2(SINE_TABLE_DEPTH) + 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  irsm_pkg::cfg_t                     cfg,
	input  logic                               in_valid,
	input  logic [PN_W-1:0]                    ph_num,
	input  logic [irsm_pkg::GW_W:0]            ph_den,
	input  logic                               w_zero,
	input  logic [irsm_pkg::ROW_W-1:0]         row,
	input  logic                               grid,
	output logic                               out_valid,
	output logic signed [irsm_pkg::OUT_W-1:0]  source_x,
	output logic signed [irsm_pkg::OUT_W-1:0]  source_y,
	output logic                               in_image,
	output logic                               in_grid
);

	localparam int LOGD   = $clog2(SINE_TABLE_DEPTH);
	localparam int LP     = LOGD + 2;
	localparam int ROM_W  = TRIG_FRAC_BITS + 1;
	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int SH     = TRIG_FRAC_BITS - irsm_pkg::COORD_FRAC;
	localparam int RAW_W  = TRIG_FRAC_BITS + 12;
	localparam int PT_W   = 20;
	localparam int NUM_W  = 32;
	localparam int I_W    = 31;
	localparam int DEN_W  = irsm_pkg::GH_W + irsm_pkg::COORD_FRAC;
	localparam int CW     = irsm_pkg::CTR_W;
	localparam int TAG_W  = irsm_pkg::ROW_W + 2;
	localparam logic [LP-1:0] THREE_D = LP'(3 * SINE_TABLE_DEPTH);
	localparam logic [LP-1:0] ONE_D   = LP'(SINE_TABLE_DEPTH);
	localparam logic [CW-1:0] CMASK   =
		(COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);
	localparam longint unsigned HALF_PI_Q30_L = irsm_pkg::HALF_PI_Q30;

	// divide by 2^SH, rounding half away from zero
	function automatic logic signed [PT_W-1:0] round_pt(input logic signed [RAW_W-1:0] v);
		logic [RAW_W-1:0] mag;
		logic [RAW_W-1:0] q;
		mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
		q   = (mag + RAW_W'(1 << (SH - 1))) >> SH;
		return v[RAW_W-1] ? -PT_W'(q) : PT_W'(q);
	endfunction

	// clamp a sign-magnitude result to the output range
	function automatic logic [irsm_pkg::OUT_W-1:0] sat_out(input logic neg,
		input logic [I_W-1:0] q);
		logic [irsm_pkg::OUT_W-1:0] r;
		if (neg) begin
			r = (q > I_W'(2048)) ? 12'h800 : -q[irsm_pkg::OUT_W-1:0];
		end else begin
			r = (q > I_W'(2047)) ? 12'h7FF : q[irsm_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	// constant quarter-wave table; entry k from a Taylor series in Q30
	logic [ROM_W-1:0] rom_w [SINE_TABLE_DEPTH + 1];
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned X   =
			(HALF_PI_Q30_L * k + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		localparam longint unsigned X2  = (X * X) >> 30;
		localparam longint unsigned T1  = ((X * X2) >> 30) / 6;
		localparam longint unsigned T2  = ((T1 * X2) >> 30) / 20;
		localparam longint unsigned T3  = ((T2 * X2) >> 30) / 42;
		localparam longint unsigned T4  = ((T3 * X2) >> 30) / 72;
		localparam longint unsigned T5  = ((T4 * X2) >> 30) / 110;
		localparam longint unsigned T6  = ((T5 * X2) >> 30) / 156;
		localparam longint unsigned T7  = ((T6 * X2) >> 30) / 210;
		localparam longint unsigned T8  = ((T7 * X2) >> 30) / 272;
		localparam longint unsigned T9  = ((T8 * X2) >> 30) / 342;
		localparam longint unsigned T10 = ((T9 * X2) >> 30) / 420;
		localparam longint unsigned T11 = ((T10 * X2) >> 30) / 506;
		localparam longint unsigned T12 = ((T11 * X2) >> 30) / 600;
		localparam longint unsigned T13 = ((T12 * X2) >> 30) / 702;
		localparam longint unsigned T14 = ((T13 * X2) >> 30) / 812;
		localparam longint unsigned T15 = ((T14 * X2) >> 30) / 930;
		localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
			- longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6)
			- longint'(T7) + longint'(T8) - longint'(T9) + longint'(T10)
			- longint'(T11) + longint'(T12) - longint'(T13) + longint'(T14)
			- longint'(T15);
		localparam longint SUMC = (SUM < 0) ? 64'sd0 : SUM;
		localparam longint unsigned V =
			(($unsigned(SUMC) << TRIG_FRAC_BITS) + (64'd1 << 29)) >> 30;
		localparam longint unsigned VC =
			(V > (64'd1 << TRIG_FRAC_BITS)) ? (64'd1 << TRIG_FRAC_BITS) : V;
		assign rom_w[k] = ROM_W'(VC);
	end

	// phase divider
	logic             ph_vld;
	logic [PN_W-1:0]  ph_q;
	logic [TAG_W-1:0] ph_tag;

	irsm_div #(.NW(PN_W), .DW(irsm_pkg::GW_W + 1), .TW(TAG_W)) u_ph_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.num       (ph_num),
		.den       (ph_den),
		.tag       ({w_zero, row, grid}),
		.out_valid (ph_vld),
		.quo       (ph_q),
		.out_tag   (ph_tag)
	);

	// phase to table index and sign, for sin(p) and cos(p) = sin(p + D)
	logic [LP-1:0]   p_s;
	logic [LP-1:0]   p_c;
	logic [LOGD:0]   idx_s;
	logic [LOGD:0]   idx_c;

	assign p_s   = ph_tag[TAG_W-1] ? THREE_D : ph_q[LP-1:0] + THREE_D;
	assign p_c   = p_s + ONE_D;
	assign idx_s = p_s[LP-2] ? ONE_D[LOGD:0] - {1'b0, p_s[LOGD-1:0]} : {1'b0, p_s[LOGD-1:0]};
	assign idx_c = p_c[LP-2] ? ONE_D[LOGD:0] - {1'b0, p_c[LOGD-1:0]} : {1'b0, p_c[LOGD-1:0]};

	// stage 1: table read
	logic                       vld_s1;
	logic [ROM_W-1:0]           smag_s1;
	logic [ROM_W-1:0]           cmag_s1;
	logic                       sneg_s1;
	logic                       cneg_s1;
	logic [irsm_pkg::ROW_W-1:0] row_s1;
	logic                       grid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ph_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smag_s1 <= rom_w[idx_s];
			cmag_s1 <= rom_w[idx_c];
			sneg_s1 <= p_s[LP-1];
			cneg_s1 <= p_c[LP-1];
			row_s1  <= ph_tag[irsm_pkg::ROW_W:1];
			grid_s1 <= ph_tag[0];
		end
	end

	// stage 2: circle points in 8 fractional bits
	logic signed [TRIG_W-1:0] sv;
	logic signed [TRIG_W-1:0] cv;
	logic signed [RAW_W-1:0]  xp_raw;
	logic signed [RAW_W-1:0]  yp_raw;
	logic signed [RAW_W-1:0]  xl_raw;
	logic signed [RAW_W-1:0]  yl_raw;

	assign sv = sneg_s1 ? -$signed({1'b0, smag_s1}) : $signed({1'b0, smag_s1});
	assign cv = cneg_s1 ? -$signed({1'b0, cmag_s1}) : $signed({1'b0, cmag_s1});

	assign xp_raw = $signed({1'b0, cfg.pupil_x & CMASK, {TRIG_FRAC_BITS{1'b0}}})
		+ $signed({1'b0, cfg.pupil_r}) * cv;
	assign yp_raw = $signed({1'b0, cfg.pupil_y & CMASK, {TRIG_FRAC_BITS{1'b0}}})
		+ $signed({1'b0, cfg.pupil_r}) * sv;
	assign xl_raw = $signed({1'b0, cfg.limbus_x & CMASK, {TRIG_FRAC_BITS{1'b0}}})
		+ $signed({1'b0, cfg.limbus_r}) * cv;
	assign yl_raw = $signed({1'b0, cfg.limbus_y & CMASK, {TRIG_FRAC_BITS{1'b0}}})
		+ $signed({1'b0, cfg.limbus_r}) * sv;

	logic                       vld_s2;
	logic signed [PT_W-1:0]     xp_s2;
	logic signed [PT_W-1:0]     yp_s2;
	logic signed [PT_W-1:0]     xl_s2;
	logic signed [PT_W-1:0]     yl_s2;
	logic [irsm_pkg::ROW_W-1:0] row_s2;
	logic                       grid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2   <= round_pt(xp_raw);
			yp_s2   <= round_pt(yp_raw);
			xl_s2   <= round_pt(xl_raw);
			yl_s2   <= round_pt(yl_raw);
			row_s2  <= row_s1;
			grid_s2 <= grid_s1;
		end
	end

	// stage 3: blend limbus and pupil points, form rounded dividend
	logic                       h_zero;
	logic [irsm_pkg::GH_W-1:0]  h;
	logic signed [11:0]         hr;
	logic signed [NUM_W-1:0]    nx;
	logic signed [NUM_W-1:0]    ny;
	logic [DEN_W-1:0]           den;
	logic [I_W-1:0]             magx;
	logic [I_W-1:0]             magy;

	assign h_zero = (cfg.limbus_r == '0);
	assign h      = {cfg.limbus_r, 1'b0};
	assign hr     = $signed({2'b0, h}) - $signed({2'b0, row_s2});
	assign nx     = h_zero ? NUM_W'(xl_s2)
		: hr * xl_s2 + $signed({1'b0, row_s2}) * xp_s2;
	assign ny     = h_zero ? NUM_W'(yl_s2)
		: hr * yl_s2 + $signed({1'b0, row_s2}) * yp_s2;
	assign den    = h_zero ? DEN_W'(1 << irsm_pkg::COORD_FRAC)
		: {h, {irsm_pkg::COORD_FRAC{1'b0}}};
	assign magx   = (nx[NUM_W-1] ? I_W'(-nx) : I_W'(nx)) + I_W'(den >> 1);
	assign magy   = (ny[NUM_W-1] ? I_W'(-ny) : I_W'(ny)) + I_W'(den >> 1);

	logic             vld_s3;
	logic [I_W-1:0]   magx_s3;
	logic [I_W-1:0]   magy_s3;
	logic             negx_s3;
	logic             negy_s3;
	logic [DEN_W-1:0] den_s3;
	logic             grid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s3 <= magx;
			magy_s3 <= magy;
			negx_s3 <= nx[NUM_W-1];
			negy_s3 <= ny[NUM_W-1];
			den_s3  <= den;
			grid_s3 <= grid_s2;
		end
	end

	// final dividers for x and y
	logic           qx_vld;
	logic           qy_vld;
	logic [I_W-1:0] qx;
	logic [I_W-1:0] qy;
	logic [1:0]     x_tag;
	logic           y_neg;

	irsm_div #(.NW(I_W), .DW(DEN_W), .TW(2)) u_x_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.num       (magx_s3),
		.den       (den_s3),
		.tag       ({negx_s3, grid_s3}),
		.out_valid (qx_vld),
		.quo       (qx),
		.out_tag   (x_tag)
	);

	irsm_div #(.NW(I_W), .DW(DEN_W), .TW(1)) u_y_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.num       (magy_s3),
		.den       (den_s3),
		.tag       (negy_s3),
		.out_valid (qy_vld),
		.quo       (qy),
		.out_tag   (y_neg)
	);

	// bounds test on the unsaturated value, then clamp
	logic x_nonneg;
	logic y_nonneg;

	assign x_nonneg  = !x_tag[1] || (qx == '0);
	assign y_nonneg  = !y_neg || (qy == '0);
	assign out_valid = qx_vld && qy_vld;
	assign source_x  = sat_out(x_tag[1], qx);
	assign source_y  = sat_out(y_neg, qy);
	assign in_grid   = x_tag[0];
	assign in_image  = x_nonneg && y_nonneg
		&& (qx < I_W'(cfg.image_width)) && (qy < I_W'(cfg.image_height));

endmodule

// ===== bench/tb_iris_rubber_sheet_coordinate_map.sv =====
// Self-checking bench for iris_rubber_sheet_coordinate_map: polar samples in,
// predicted source coordinates compared per field. Depends on irsm_pkg and the RTL.
module tb_iris_rubber_sheet_coordinate_map;
	import irsm_pkg::*;

	localparam int DEPTH     = DEF_SINE_TABLE_DEPTH;
	localparam int TRIG_FRAC = DEF_TRIG_FRAC_BITS;
	localparam int LATENCY   = $clog2(DEPTH) + 51;
	localparam int LIMIT     = 2000000;

	typedef struct {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} sample_t;

	typedef struct {
		logic [OUT_W-1:0] sx;
		logic [OUT_W-1:0] sy;
		logic             img;
		logic             grid;
	} coord_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic push, full, empty, pop;
	logic [COL_W-1:0] angle_column;
	logic [ROW_W-1:0] radial_row;
	logic signed [OUT_W-1:0] source_x, source_y;
	logic in_image, in_grid;

	iris_rubber_sheet_coordinate_map u_dut (.*);

	// shadow of the configuration registers
	longint unsigned m_px, m_py, m_pr, m_lx, m_ly, m_lr, m_iw, m_ih;
	longint unsigned sine_tab[0:DEPTH];

	sample_t pending[$];
	coord_t  coords_due[$];
	int idle_pct, stall_pct;
	int cycles;
	bit took, failed;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// quarter-wave table from a Taylor series in Q30
	function automatic void build_sine();
		longint unsigned x, x2, term, v;
		longint s;
		for (int k = 0; k <= DEPTH; k++) begin
			x = (HALF_PI_Q30 * k + DEPTH / 2) / DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			s = x;
			for (int n = 1; n <= 15; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2) s -= term;
				else s += term;
			end
			if (s < 0) s = 0;
			v = ((longint'(s) << TRIG_FRAC) + (64'd1 << 29)) >> 30;
			if (v > (64'd1 << TRIG_FRAC)) v = 64'd1 << TRIG_FRAC;
			sine_tab[k] = v;
		end
	endfunction

	function automatic longint sine_of(longint unsigned p);
		longint unsigned q, r;
		p = p % (4 * DEPTH);
		q = p / DEPTH;
		r = p % DEPTH;
		case (q)
			0: return sine_tab[r];
			1: return sine_tab[DEPTH - r];
			2: return -longint'(sine_tab[r]);
			default: return -longint'(sine_tab[DEPTH - r]);
		endcase
	endfunction

	// divide rounding half away from zero
	function automatic longint rdiv(longint num, longint den);
		longint unsigned mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [OUT_W-1:0] clamp12(longint v);
		if (v < -2048) return 12'h800;
		if (v > 2047) return 12'h7FF;
		return v[OUT_W-1:0];
	endfunction

	function automatic coord_t map_sample(sample_t it);
		coord_t r;
		longint unsigned h, w, p, cm;
		longint c, s, fs, xp, yp, xl, yl, x, y, one, rr, den;
		cm = (64'd1 << DEF_COORD_BITS) - 1;
		h = 2 * m_lr;
		w = (h * 64'(PI_Q32) + (64'd1 << 31)) >> 32;
		p = 3 * DEPTH;
		if (w != 0) p += (2 * longint'(it.col) * 4 * DEPTH + w) / (2 * w);
		p = p % (4 * DEPTH);
		s = sine_of(p);
		c = sine_of(p + DEPTH);
		one = 64'd1 << TRIG_FRAC;
		fs = 64'd1 << (TRIG_FRAC - COORD_FRAC);
		xp = rdiv(longint'(m_px & cm) * one + longint'(m_pr) * c, fs);
		yp = rdiv(longint'(m_py & cm) * one + longint'(m_pr) * s, fs);
		xl = rdiv(longint'(m_lx & cm) * one + longint'(m_lr) * c, fs);
		yl = rdiv(longint'(m_ly & cm) * one + longint'(m_lr) * s, fs);
		if (h == 0) begin
			x = rdiv(xl, 64'd1 << COORD_FRAC);
			y = rdiv(yl, 64'd1 << COORD_FRAC);
		end else begin
			rr = it.row;
			den = longint'(h) << COORD_FRAC;
			x = rdiv((longint'(h) - rr) * xl + rr * xp, den);
			y = rdiv((longint'(h) - rr) * yl + rr * yp, den);
		end
		r.sx = clamp12(x);
		r.sy = clamp12(y);
		r.img = (x >= 0 && y >= 0 && x < longint'(m_iw) && y < longint'(m_ih));
		r.grid = (it.col < w && it.row < h);
		return r;
	endfunction

	// driver: next transaction or idle, one update per falling edge
	always @(negedge clk) begin
		sample_t nx;
		if (!push || took) begin
			if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nx = pending.pop_front();
				push <= 1'b1;
				angle_column <= nx.col;
				radial_row <= nx.row;
			end else begin
				push <= 1'b0;
			end
		end
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: predict on accepted input, check on accepted result
	always @(posedge clk) begin
		sample_t it;
		coord_t e;
		cycles++;
		took = push && !full;
		if (arst_n) begin
			if (took) begin
				it.col = angle_column;
				it.row = radial_row;
				coords_due.insert(coords_due.size(), map_sample(it));
			end
			if (pop && !empty) begin
				if (coords_due.size() == 0) begin
					$error("result with no sample outstanding");
					failed = 1;
				end else begin
					e = coords_due.pop_front();
					if (source_x !== e.sx) begin
						$error("source_x expected %0d got %0d", $signed(e.sx), source_x);
						failed = 1;
					end
					if (source_y !== e.sy) begin
						$error("source_y expected %0d got %0d", $signed(e.sy), source_y);
						failed = 1;
					end
					if (in_image !== e.img) begin
						$error("in_image expected %0b got %0b", e.img, in_image);
						failed = 1;
					end
					if (in_grid !== e.grid) begin
						$error("in_grid expected %0b got %0b", e.grid, in_grid);
						failed = 1;
					end
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, longint unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_PUPIL_X:     m_px = val & 10'h3FF;
			REG_PUPIL_Y:     m_py = val & 10'h3FF;
			REG_PUPIL_R:     m_pr = val & 9'h1FF;
			REG_LIMBUS_X:    m_lx = val & 10'h3FF;
			REG_LIMBUS_Y:    m_ly = val & 10'h3FF;
			REG_LIMBUS_R:    m_lr = val & 9'h1FF;
			REG_IMAGE_WIDTH: m_iw = val & 11'h7FF;
			default:         m_ih = val & 11'h7FF;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(int px, int py, int pr, int lx, int ly, int lr, int iw, int ih);
		while (pending.size() > 0 || push || coords_due.size() > 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		write_reg(REG_PUPIL_X, px);
		write_reg(REG_PUPIL_Y, py);
		write_reg(REG_PUPIL_R, pr);
		write_reg(REG_LIMBUS_X, lx);
		write_reg(REG_LIMBUS_Y, ly);
		write_reg(REG_LIMBUS_R, lr);
		write_reg(REG_IMAGE_WIDTH, iw);
		write_reg(REG_IMAGE_HEIGHT, ih);
	endtask

	task automatic add(int col, int row);
		sample_t it;
		it.col = col;
		it.row = row;
		pending.insert(pending.size(), it);
	endtask

	// random samples, mostly on the grid, some anywhere in the field range
	task automatic add_random(int n);
		int h, w;
		h = 2 * m_lr;
		w = (longint'(h) * 64'(PI_Q32) + (64'd1 << 31)) >> 32;
		repeat (n) begin
			if ($urandom_range(9) < 7 && w > 0)
				add($urandom_range(w - 1), $urandom_range(h > 1023 ? 1023 : h - 1));
			else
				add($urandom_range(4095), $urandom_range(1023));
		end
	endtask

	initial begin
		int px, py, pr, lx, ly, lr, iw, ih;
		arst_n = 0;
		push = 0;
		pop = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		angle_column = '0;
		radial_row = '0;
		idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		failed = 0;
		took = 0;
		build_sine();
		m_px = 0; m_py = 0; m_pr = 0; m_lx = 0; m_ly = 0; m_lr = 1; m_iw = 1024; m_ih = 1024;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: grid is 6 columns by 2 rows
		add(0, 0); add(5, 1); add(6, 2); add(4095, 1023);

		// typical eye, edges of the grid (h = 200, w = 628)
		setup(512, 400, 40, 500, 410, 100, 1024, 768);
		add(0, 0); add(627, 199); add(628, 200); add(157, 0); add(314, 100);
		add(471, 199); add(4095, 0); add(0, 1023);

		// zero limbus radius
		setup(100, 100, 10, 300, 200, 0, 640, 480);
		add(0, 0); add(77, 512);

		// saturation and extrapolation far past the pupil
		setup(0, 0, 511, 1023, 1023, 511, 2047, 2047);
		add(0, 1023); add(1605, 1023); add(2000, 1023); add(0, 0);

		// zero image size and largest pupil centre
		setup(1023, 1023, 0, 0, 0, 1, 0, 0);
		add(3, 1); add(4095, 1023);
		add_random(60);

		for (int ph = 0; ph < 10; ph++) begin
			px = $urandom_range(1023); py = $urandom_range(1023);
			lx = $urandom_range(1023); ly = $urandom_range(1023);
			pr = $urandom_range(511);
			lr = (ph % 4 == 0) ? 511 : (ph % 4 == 1) ? 1 : $urandom_range(300, 1);
			iw = (ph == 3) ? 2047 : $urandom_range(1024, 1);
			ih = (ph == 3) ? 2047 : $urandom_range(1024, 1);
			setup(px, py, pr, lx, ly, lr, iw, ih);
			idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 64 : 32) : 0;
			stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 32 : 0;
			add_random(135);
		end

		while (pending.size() > 0 || push || coords_due.size() > 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== iris_rubber_sheet_coordinate_map.f =====
+incdir+hw/rtl
hw/rtl/irsm_pkg.sv
hw/rtl/irsm_fifo.sv
hw/rtl/irsm_div.sv
hw/rtl/irsm_front.sv
hw/rtl/irsm_back.sv
hw/rtl/iris_rubber_sheet_coordinate_map.sv
bench/tb_iris_rubber_sheet_coordinate_map.sv
